[sv/osd_pkg.sv]
// Shared types and constants for the opcode subset decoder.
// Field encodings of the decoded result and the packed beat layouts.
// No dependencies.
`default_nettype none

package osd_pkg;

	localparam int unsigned IN_BITS  = 40;
	localparam int unsigned OUT_BITS = 56;

	typedef enum logic [4:0] {
		KIND_NOP  = 5'd0,
		KIND_LD   = 5'd1,
		KIND_INC  = 5'd2,
		KIND_DEC  = 5'd3,
		KIND_RLCA = 5'd4,
		KIND_STOP = 5'd5,
		KIND_JR   = 5'd6,
		KIND_ADD  = 5'd7,
		KIND_RRA  = 5'd8,
		KIND_ADC  = 5'd9,
		KIND_XOR  = 5'd10,
		KIND_OR   = 5'd11,
		KIND_RET  = 5'd12,
		KIND_POP  = 5'd13,
		KIND_JP   = 5'd14,
		KIND_PUSH = 5'd15,
		KIND_CALL = 5'd16,
		KIND_SUB  = 5'd17,
		KIND_LDH  = 5'd18,
		KIND_AND  = 5'd19,
		KIND_DI   = 5'd20,
		KIND_CP   = 5'd21,
		KIND_RR   = 5'd22,
		KIND_SRL  = 5'd23
	} kind_t;

	typedef enum logic [3:0] {
		MODE_NONE     = 4'd0,
		MODE_N16_R16  = 4'd1,
		MODE_N8_R8    = 4'd2,
		MODE_R16_A    = 4'd3,
		MODE_A_R16    = 4'd4,
		MODE_A_HLI    = 4'd5,
		MODE_HLI_A    = 4'd6,
		MODE_A_HLD    = 4'd7,
		MODE_REG_REG  = 4'd8,
		MODE_HL_REG   = 4'd9,
		MODE_REG_HL   = 4'd10,
		MODE_A_A16    = 4'd11,
		MODE_A16_A    = 4'd12,
		MODE_LDH_OUT  = 4'd13,
		MODE_LDH_IN   = 4'd14,
		MODE_IMM      = 4'd15
	} mode_t;

	typedef enum logic [3:0] {
		REG_NONE = 4'd0,
		REG_A    = 4'd1,
		REG_B    = 4'd2,
		REG_C    = 4'd3,
		REG_D    = 4'd4,
		REG_E    = 4'd5,
		REG_H    = 4'd6,
		REG_L    = 4'd7,
		REG_AF   = 4'd8,
		REG_BC   = 4'd9,
		REG_DE   = 4'd10,
		REG_HL   = 4'd11,
		REG_SP   = 4'd12
	} reg_t;

	typedef enum logic [1:0] {
		COND_ALWAYS = 2'd0,
		COND_ZERO   = 2'd1,
		COND_CARRY  = 2'd2
	} cond_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BAD_OP = 2'd1,
		STAT_BAD_CB = 2'd2
	} status_t;

	// Restart targets
	localparam logic [15:0] RST_VEC_08 = 16'h0008;
	localparam logic [15:0] RST_VEC_28 = 16'h0028;
	localparam logic [15:0] RST_VEC_30 = 16'h0030;
	localparam logic [15:0] RST_VEC_38 = 16'h0038;

	// Input beat, first member in the top bits
	typedef struct packed {
		logic [15:0] pc_offset;
		logic [7:0]  third_byte;
		logic [7:0]  next_byte;
		logic [7:0]  opcode;
	} in_t;

	// Result beat, first member in the top bits
	typedef struct packed {
		status_t     status;
		logic [1:0]  length;
		logic [15:0] return_address;
		logic [15:0] immediate;
		logic        cond_negate;
		cond_t       cond_flag;
		reg_t        second_reg;
		reg_t        first_reg;
		mode_t       mode;
		kind_t       kind;
	} res_t;

endpackage

`default_nettype wire

[sv/opcode_subset_decoder.sv]
// Top level of the opcode subset decoder: input register, decode table and
// result register on stream ports. Depends on osd_pkg and osd_decode.
`default_nettype none

// One instruction beat is accepted every cycle while the result side keeps
// taking beats; an accepted beat is held in the input register, with the
// table lookup and the return-address adders behind it, and its decoded
// result is then offered from the result register. A stalled result holds
// in the result register while the input register still takes one more
// beat.
// Unknown opcodes are not fatal: they come out with status 1 (or 2 for an
// unknown CB sub-opcode), their length, and all other fields zero.
module opcode_subset_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// opcode[7:0], next_byte[15:8], third_byte[23:16], pc_offset[39:24]
	input  wire logic [osd_pkg::IN_BITS-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// kind[4:0], mode[8:5], first_reg[12:9], second_reg[16:13],
	// cond_flag[18:17], cond_negate[19], immediate[35:20],
	// return_address[51:36], length[53:52], status[55:54]
	output logic [osd_pkg::OUT_BITS-1:0]        m_tdata
);
	import osd_pkg::*;

	logic valid_s1;
	logic valid_s2;
	in_t  instr_s1;
	res_t res_s2;
	res_t dec;
	logic adv_s2;
	logic take_s1;

	// advance into the result register when it is empty or being drained
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign take_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			instr_s1 <= in_t'(s_tdata);
		end
	end

	osd_decode u_decode (
		.instr (instr_s1),
		.dec   (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= dec;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

`ifndef SYNTHESIS
	// an accepted beat always lands in the input register
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> valid_s1)
		else $error("accepted beat did not reach the input register");

	// an empty input register never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	// a held input beat moves on once the result register drains
	a_drain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && m_tready) |=> valid_s2)
		else $error("result register emptied while a beat was waiting");

	// unknown opcodes carry only status and length
	a_bad_op_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.status == STAT_BAD_OP) |->
		(res_s2.length == 2'd1 && res_s2.immediate == 16'h0 &&
		 res_s2.return_address == 16'h0 && res_s2.kind == KIND_NOP))
		else $error("unknown opcode result carries payload");

	// only calls and restarts produce a return address
	a_ret_only_call: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.return_address != 16'h0) |->
		(res_s2.kind == KIND_CALL))
		else $error("return address on a non-call instruction");
`endif

endmodule

`default_nettype wire

[sv/osd_decode.sv]
// Instruction table of the opcode subset decoder: maps one fetched
// instruction to its decoded result. Pure combinational logic.
// Depends on osd_pkg.
`default_nettype none

module osd_decode (
	input  osd_pkg::in_t  instr,
	output osd_pkg::res_t dec
);
	import osd_pkg::*;

	localparam logic [7:0] OP_PREFIX_CB = 8'hCB;
	localparam logic [7:0] OP_CALL      = 8'hCD;
	localparam logic [7:0] OP_RST_08    = 8'hCF;
	localparam logic [7:0] OP_RST_28    = 8'hEF;
	localparam logic [7:0] OP_RST_30    = 8'hF7;
	localparam logic [7:0] OP_RST_38    = 8'hFF;
	localparam logic [7:0] CB_RR_C      = 8'h19;
	localparam logic [7:0] CB_SRL_B     = 8'h38;
	localparam logic [7:0] CB_SRL_A     = 8'h3F;

	function automatic res_t put(kind_t k, mode_t m, reg_t r1, reg_t r2,
			logic [15:0] imm, logic [1:0] len);
		res_t r;
		r                = '0;
		r.kind           = k;
		r.mode           = m;
		r.first_reg      = r1;
		r.second_reg     = r2;
		r.immediate      = imm;
		r.length         = len;
		r.status         = STAT_OK;
		return r;
	endfunction

	logic [15:0] n8;
	logic [15:0] n16;
	logic [15:0] ret_call;
	logic [15:0] ret_rst;

	assign n8       = {8'h00, instr.next_byte};
	assign n16      = {instr.third_byte, instr.next_byte};
	assign ret_call = instr.pc_offset + 16'd3;
	assign ret_rst  = instr.pc_offset + 16'd1;

	always_comb begin
		dec = '0;
		unique case (instr.opcode)
			8'h00: dec = put(KIND_NOP,  MODE_NONE,    REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'h01: dec = put(KIND_LD,   MODE_N16_R16, REG_BC,   REG_NONE, n16,   2'd3);
			8'h03: dec = put(KIND_INC,  MODE_NONE,    REG_BC,   REG_NONE, 16'h0, 2'd1);
			8'h04: dec = put(KIND_INC,  MODE_NONE,    REG_B,    REG_NONE, 16'h0, 2'd1);
			8'h05: dec = put(KIND_DEC,  MODE_NONE,    REG_B,    REG_NONE, 16'h0, 2'd1);
			8'h06: dec = put(KIND_LD,   MODE_N8_R8,   REG_B,    REG_NONE, n8,    2'd2);
			8'h07: dec = put(KIND_RLCA, MODE_NONE,    REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'h0A: dec = put(KIND_LD,   MODE_R16_A,   REG_BC,   REG_NONE, 16'h0, 2'd1);
			8'h0B: dec = put(KIND_DEC,  MODE_NONE,    REG_BC,   REG_NONE, 16'h0, 2'd1);
			8'h0C: dec = put(KIND_INC,  MODE_NONE,    REG_C,    REG_NONE, 16'h0, 2'd1);
			8'h0D: dec = put(KIND_DEC,  MODE_NONE,    REG_C,    REG_NONE, 16'h0, 2'd1);
			8'h0E: dec = put(KIND_LD,   MODE_N8_R8,   REG_C,    REG_NONE, n8,    2'd2);
			8'h10: dec = put(KIND_STOP, MODE_NONE,    REG_NONE, REG_NONE, n8,    2'd2);
			8'h11: dec = put(KIND_LD,   MODE_N16_R16, REG_DE,   REG_NONE, n16,   2'd3);
			8'h12: dec = put(KIND_LD,   MODE_A_R16,   REG_DE,   REG_NONE, 16'h0, 2'd1);
			8'h13: dec = put(KIND_INC,  MODE_NONE,    REG_DE,   REG_NONE, 16'h0, 2'd1);
			8'h14: dec = put(KIND_INC,  MODE_NONE,    REG_D,    REG_NONE, 16'h0, 2'd1);
			8'h18: dec = put(KIND_JR,   MODE_NONE,    REG_NONE, REG_NONE, n8,    2'd2);
			8'h19: dec = put(KIND_ADD,  MODE_NONE,    REG_DE,   REG_NONE, 16'h0, 2'd1);
			8'h1A: dec = put(KIND_LD,   MODE_R16_A,   REG_DE,   REG_NONE, 16'h0, 2'd1);
			8'h1C: dec = put(KIND_INC,  MODE_NONE,    REG_E,    REG_NONE, 16'h0, 2'd1);
			8'h1F: dec = put(KIND_RRA,  MODE_NONE,    REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'h20: begin
				dec = put(KIND_JR, MODE_NONE, REG_NONE, REG_NONE, n8, 2'd2);
				dec.cond_flag   = COND_ZERO;
				dec.cond_negate = 1'b1;
			end
			8'h21: dec = put(KIND_LD,   MODE_N16_R16, REG_HL,   REG_NONE, n16,   2'd3);
			8'h22: dec = put(KIND_LD,   MODE_A_HLI,   REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'h23: dec = put(KIND_INC,  MODE_NONE,    REG_HL,   REG_NONE, 16'h0, 2'd1);
			8'h24: dec = put(KIND_INC,  MODE_NONE,    REG_H,    REG_NONE, 16'h0, 2'd1);
			8'h28: begin
				dec = put(KIND_JR, MODE_NONE, REG_NONE, REG_NONE, n8, 2'd2);
				dec.cond_flag   = COND_ZERO;
			end
			8'h2A: dec = put(KIND_LD,   MODE_HLI_A,   REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'h2C: dec = put(KIND_INC,  MODE_NONE,    REG_L,    REG_NONE, 16'h0, 2'd1);
			8'h30: begin
				dec = put(KIND_JR, MODE_NONE, REG_NONE, REG_NONE, n8, 2'd2);
				dec.cond_flag   = COND_CARRY;
				dec.cond_negate = 1'b1;
			end
			8'h31: dec = put(KIND_LD,   MODE_N16_R16, REG_SP,   REG_NONE, n16,   2'd3);
			8'h32: dec = put(KIND_LD,   MODE_A_HLD,   REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'h3C: dec = put(KIND_INC,  MODE_NONE,    REG_A,    REG_NONE, 16'h0, 2'd1);
			8'h3D: dec = put(KIND_DEC,  MODE_NONE,    REG_A,    REG_NONE, 16'h0, 2'd1);
			8'h3E: dec = put(KIND_LD,   MODE_N8_R8,   REG_A,    REG_NONE, n8,    2'd2);
			// register moves: first is the source, second the destination
			8'h40: dec = put(KIND_LD,   MODE_REG_REG, REG_B,    REG_B,    16'h0, 2'd1);
			8'h47: dec = put(KIND_LD,   MODE_REG_REG, REG_A,    REG_B,    16'h0, 2'd1);
			8'h54: dec = put(KIND_LD,   MODE_REG_REG, REG_H,    REG_D,    16'h0, 2'd1);
			8'h57: dec = put(KIND_LD,   MODE_REG_REG, REG_A,    REG_D,    16'h0, 2'd1);
			8'h58: dec = put(KIND_LD,   MODE_REG_REG, REG_B,    REG_E,    16'h0, 2'd1);
			8'h5D: dec = put(KIND_LD,   MODE_REG_REG, REG_L,    REG_E,    16'h0, 2'd1);
			8'h5F: dec = put(KIND_LD,   MODE_REG_REG, REG_A,    REG_E,    16'h0, 2'd1);
			8'h63: dec = put(KIND_LD,   MODE_REG_REG, REG_E,    REG_H,    16'h0, 2'd1);
			8'h67: dec = put(KIND_LD,   MODE_REG_REG, REG_A,    REG_H,    16'h0, 2'd1);
			8'h69: dec = put(KIND_LD,   MODE_REG_REG, REG_C,    REG_L,    16'h0, 2'd1);
			8'h6E: dec = put(KIND_LD,   MODE_HL_REG,  REG_L,    REG_NONE, 16'h0, 2'd1);
			8'h6F: dec = put(KIND_LD,   MODE_REG_REG, REG_A,    REG_L,    16'h0, 2'd1);
			8'h70: dec = put(KIND_LD,   MODE_REG_HL,  REG_B,    REG_NONE, 16'h0, 2'd1);
			8'h71: dec = put(KIND_LD,   MODE_REG_HL,  REG_C,    REG_NONE, 16'h0, 2'd1);
			8'h72: dec = put(KIND_LD,   MODE_REG_HL,  REG_D,    REG_NONE, 16'h0, 2'd1);
			8'h73: dec = put(KIND_LD,   MODE_REG_HL,  REG_E,    REG_NONE, 16'h0, 2'd1);
			8'h74: dec = put(KIND_LD,   MODE_REG_HL,  REG_H,    REG_NONE, 16'h0, 2'd1);
			8'h75: dec = put(KIND_LD,   MODE_REG_HL,  REG_L,    REG_NONE, 16'h0, 2'd1);
			8'h77: dec = put(KIND_LD,   MODE_REG_HL,  REG_A,    REG_NONE, 16'h0, 2'd1);
			8'h78: dec = put(KIND_LD,   MODE_REG_REG, REG_B,    REG_A,    16'h0, 2'd1);
			8'h7A: dec = put(KIND_LD,   MODE_REG_REG, REG_D,    REG_A,    16'h0, 2'd1);
			8'h7C: dec = put(KIND_LD,   MODE_REG_REG, REG_H,    REG_A,    16'h0, 2'd1);
			8'h7D: dec = put(KIND_LD,   MODE_REG_REG, REG_L,    REG_A,    16'h0, 2'd1);
			8'h80: dec = put(KIND_ADD,  MODE_NONE,    REG_B,    REG_NONE, 16'h0, 2'd1);
			8'h8D: dec = put(KIND_ADC,  MODE_NONE,    REG_L,    REG_NONE, 16'h0, 2'd1);
			8'hA9: dec = put(KIND_XOR,  MODE_NONE,    REG_C,    REG_NONE, 16'h0, 2'd1);
			8'hAF: dec = put(KIND_XOR,  MODE_NONE,    REG_A,    REG_NONE, 16'h0, 2'd1);
			8'hB0: dec = put(KIND_OR,   MODE_NONE,    REG_B,    REG_NONE, 16'h0, 2'd1);
			8'hB1: dec = put(KIND_OR,   MODE_NONE,    REG_C,    REG_NONE, 16'h0, 2'd1);
			8'hC0: begin
				dec = put(KIND_RET, MODE_NONE, REG_NONE, REG_NONE, 16'h0, 2'd1);
				dec.cond_flag   = COND_ZERO;
				dec.cond_negate = 1'b1;
			end
			8'hC1: dec = put(KIND_POP,  MODE_NONE,    REG_BC,   REG_NONE, 16'h0, 2'd1);
			8'hC3: dec = put(KIND_JP,   MODE_NONE,    REG_NONE, REG_NONE, n16,   2'd3);
			8'hC5: dec = put(KIND_PUSH, MODE_NONE,    REG_BC,   REG_NONE, 16'h0, 2'd1);
			8'hC6: dec = put(KIND_ADD,  MODE_IMM,     REG_NONE, REG_NONE, n8,    2'd2);
			8'hC8: begin
				dec = put(KIND_RET, MODE_NONE, REG_NONE, REG_NONE, 16'h0, 2'd1);
				dec.cond_flag   = COND_ZERO;
			end
			8'hC9: dec = put(KIND_RET,  MODE_NONE,    REG_NONE, REG_NONE, 16'h0, 2'd1);
			OP_PREFIX_CB: begin
				unique case (instr.next_byte)
					CB_RR_C:  dec = put(KIND_RR,  MODE_NONE, REG_C, REG_NONE, 16'h0, 2'd2);
					CB_SRL_B: dec = put(KIND_SRL, MODE_NONE, REG_B, REG_NONE, 16'h0, 2'd2);
					CB_SRL_A: dec = put(KIND_SRL, MODE_NONE, REG_A, REG_NONE, 16'h0, 2'd2);
					default: begin
						dec.length = 2'd2;
						dec.status = STAT_BAD_CB;
					end
				endcase
			end
			OP_CALL: begin
				dec = put(KIND_CALL, MODE_NONE, REG_NONE, REG_NONE, n16, 2'd3);
				dec.return_address = ret_call;
			end
			8'hCE: dec = put(KIND_ADC,  MODE_IMM,     REG_NONE, REG_NONE, n8,    2'd2);
			OP_RST_08: begin
				dec = put(KIND_CALL, MODE_NONE, REG_NONE, REG_NONE, RST_VEC_08, 2'd1);
				dec.return_address = ret_rst;
			end
			8'hD0: begin
				dec = put(KIND_RET, MODE_NONE, REG_NONE, REG_NONE, 16'h0, 2'd1);
				dec.cond_flag   = COND_CARRY;
				dec.cond_negate = 1'b1;
			end
			8'hD1: dec = put(KIND_POP,  MODE_NONE,    REG_DE,   REG_NONE, 16'h0, 2'd1);
			8'hD5: dec = put(KIND_PUSH, MODE_NONE,    REG_DE,   REG_NONE, 16'h0, 2'd1);
			8'hD6: dec = put(KIND_SUB,  MODE_IMM,     REG_NONE, REG_NONE, n8,    2'd2);
			8'hE0: dec = put(KIND_LDH,  MODE_LDH_OUT, REG_NONE, REG_NONE, n8,    2'd2);
			8'hE1: dec = put(KIND_POP,  MODE_NONE,    REG_HL,   REG_NONE, 16'h0, 2'd1);
			8'hE5: dec = put(KIND_PUSH, MODE_NONE,    REG_HL,   REG_NONE, 16'h0, 2'd1);
			8'hE6: dec = put(KIND_AND,  MODE_IMM,     REG_NONE, REG_NONE, n8,    2'd2);
			// jump to HL: told apart from the absolute jump by its length
			8'hE9: dec = put(KIND_JP,   MODE_NONE,    REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'hEA: dec = put(KIND_LD,   MODE_A_A16,   REG_NONE, REG_NONE, n16,   2'd3);
			OP_RST_28: begin
				dec = put(KIND_CALL, MODE_NONE, REG_NONE, REG_NONE, RST_VEC_28, 2'd1);
				dec.return_address = ret_rst;
			end
			8'hF0: dec = put(KIND_LDH,  MODE_LDH_IN,  REG_NONE, REG_NONE, n8,    2'd2);
			8'hF1: dec = put(KIND_POP,  MODE_NONE,    REG_AF,   REG_NONE, 16'h0, 2'd1);
			8'hF3: dec = put(KIND_DI,   MODE_NONE,    REG_NONE, REG_NONE, 16'h0, 2'd1);
			8'hF5: dec = put(KIND_PUSH, MODE_NONE,    REG_AF,   REG_NONE, 16'h0, 2'd1);
			OP_RST_30: begin
				dec = put(KIND_CALL, MODE_NONE, REG_NONE, REG_NONE, RST_VEC_30, 2'd1);
				dec.return_address = ret_rst;
			end
			8'hFA: dec = put(KIND_LD,   MODE_A16_A,   REG_NONE, REG_NONE, n16,   2'd3);
			8'hFE: dec = put(KIND_CP,   MODE_IMM,     REG_NONE, REG_NONE, n8,    2'd2);
			OP_RST_38: begin
				dec = put(KIND_CALL, MODE_NONE, REG_NONE, REG_NONE, RST_VEC_38, 2'd1);
				dec.return_address = ret_rst;
			end
			default: begin
				dec.length = 2'd1;
				dec.status = STAT_BAD_OP;
			end
		endcase
	end

endmodule

`default_nettype wire
